>>> sv/forward_backward_asymmetry_histogram_assert.svh
// Assertion macros used by the histogram top level.
`ifndef FORWARD_BACKWARD_ASYMMETRY_HISTOGRAM_ASSERT_SVH
`define FORWARD_BACKWARD_ASYMMETRY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication.
`define FBAH_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbah assertion failed");

// Next-cycle implication.
`define FBAH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbah assertion failed");

`endif

>>> sv/fbah_pkg.sv
`timescale 1ns / 1ps
package fbah_pkg;

   localparam int BINS       = 64;
   localparam int COUNT_BITS = 32;

   localparam int BIN_IDX_W   = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int IN_BIN_W    = 10;
   localparam int READ_CMP_W  = IN_BIN_W + 1;
   localparam int MASS_W      = 16;
   localparam int ANGLE_W     = 16;
   localparam int ASYM_W      = 16;
   localparam int OUT_COUNT_W = 32;
   localparam int CSR_INDEX_W = 2;

   // Q1.15 asymmetry: 15 fraction bits, quotient needs one more for +1.0
   localparam int FRAC_BITS  = 15;
   localparam int ASYM_STEPS = FRAC_BITS + 1;
   localparam int QUOT_W     = ASYM_STEPS;
   localparam int STEP_W     = $clog2(ASYM_STEPS + 1);
   localparam int SUM_W      = COUNT_BITS + 1;
   localparam int DIV_NW     = (COUNT_BITS + FRAC_BITS + 1 > MASS_W + BIN_IDX_W) ?
                               (COUNT_BITS + FRAC_BITS + 1) : (MASS_W + BIN_IDX_W);

   localparam logic [ANGLE_W-1:0]    ANGLE_INVALID  = 16'h8000;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;
   localparam logic [MASS_W-1:0]     MAX_MASS_RESET = 16'hFFFF;
   localparam logic [ASYM_W-1:0]     ASYM_POS_MAX   = 16'h7FFF;

   typedef enum logic [0:0] {
      CMD_EVENT = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_MASS = 2'd0,
      CSR_MAX_MASS = 2'd1
   } csr_index_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [ANGLE_W-1:0]  gen_angle;
      logic [MASS_W-1:0]          gen_mass;
      logic signed [ANGLE_W-1:0]  reco_angle;
      logic [MASS_W-1:0]          reco_mass;
      logic [IN_BIN_W-1:0]        read_bin;
   } req_type;

   typedef struct packed {
      logic [IN_BIN_W-1:0]        out_bin;
      logic [OUT_COUNT_W-1:0]     gen_forward;
      logic [OUT_COUNT_W-1:0]     gen_backward;
      logic [OUT_COUNT_W-1:0]     reco_forward;
      logic [OUT_COUNT_W-1:0]     reco_backward;
      logic signed [ASYM_W-1:0]   gen_asym;
      logic signed [ASYM_W-1:0]   reco_asym;
   } rsp_type;

   typedef struct packed {
      logic                       start;
      logic                       rd;
      logic [ANGLE_W-1:0]         angle;
      logic [MASS_W-1:0]          mass;
      logic [IN_BIN_W-1:0]        bin;
   } lane_cmd_type;

   typedef struct packed {
      logic                       idle;
      logic                       done;
      logic [COUNT_BITS-1:0]      forward;
      logic [COUNT_BITS-1:0]      backward;
      logic signed [ASYM_W-1:0]   asym;
   } lane_stat_type;

   typedef struct packed {
      logic                       start;
      logic [STEP_W-1:0]          steps;
      logic [DIV_NW-1:0]          num;
      logic [DIV_NW-1:0]          den;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic [QUOT_W-1:0]          quot;
   } div_rsp_type;

endpackage

>>> sv/fbah_ram.sv
`timescale 1ns / 1ps
module fbah_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fbah_div.sv
`timescale 1ns / 1ps
module fbah_div
   import fbah_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Restoring divider, one quotient bit per cycle. The caller hands in the
   // divisor already aligned to the top quotient bit.
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      fits    = rem_ff >= den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.num;
         den_in  = req.den;
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         den_in  = den_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

>>> sv/fbah_lane.sv
`timescale 1ns / 1ps
module fbah_lane
   import fbah_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [MASS_W-1:0] min_mass,
   input  logic [MASS_W-1:0] max_mass,
   input  lane_cmd_type      cmd,
   input  logic              take,
   output lane_stat_type     stat
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_BIN   = 8'b0000_0010,
      S_INC   = 8'b0000_0100,
      S_FETCH = 8'b0000_1000,
      S_PREP  = 8'b0001_0000,
      S_DIVGO = 8'b0010_0000,
      S_ASYM  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [BINS-1:0]          valid_f_ff, valid_f_in;
   logic [BINS-1:0]          valid_b_ff, valid_b_in;
   logic [BIN_IDX_W-1:0]     addr_ff, addr_in;
   logic                     fwd_ff, fwd_in;
   logic                     zero_ff, zero_in;
   logic [COUNT_BITS-1:0]    f_ff, f_in;
   logic [COUNT_BITS-1:0]    b_ff, b_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [COUNT_BITS-1:0]    diff_ff, diff_in;
   logic                     neg_ff, neg_in;
   logic signed [ASYM_W-1:0] asym_ff, asym_in;

   logic [BIN_IDX_W-1:0]  rd_addr;
   logic [COUNT_BITS-1:0] rdata_f, rdata_b;
   logic [COUNT_BITS-1:0] cur_f, cur_b, cur;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  wr_en_f, wr_en_b;
   logic                  in_range;
   logic [MASS_W-1:0]     mass_off, span;
   logic [DIV_NW-1:0]     bin_num;
   logic [QUOT_W-1:0]     mag;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   fbah_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (wr_en_f),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_f)
   );

   fbah_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_bwd_ram (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata_b)
   );

   fbah_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // never-written entries read as zero
   assign cur_f = valid_f_ff[addr_ff] ? rdata_f : '0;
   assign cur_b = valid_b_ff[addr_ff] ? rdata_b : '0;
   assign cur   = fwd_ff ? cur_f : cur_b;

   assign in_range = (cmd.angle != ANGLE_INVALID) && (max_mass > min_mass) &&
                     (cmd.mass >= min_mass) && (cmd.mass < max_mass);
   assign mass_off = cmd.mass - min_mass;
   assign span     = max_mass - min_mass;
   assign bin_num  = DIV_NW'(32'(mass_off) * 32'(BINS));
   assign mag      = div_rsp.quot;

   always_comb begin
      state_in   = state_ff;
      valid_f_in = valid_f_ff;
      valid_b_in = valid_b_ff;
      addr_in    = addr_ff;
      fwd_in     = fwd_ff;
      zero_in    = zero_ff;
      f_in       = f_ff;
      b_in       = b_ff;
      sum_in     = sum_ff;
      diff_in    = diff_ff;
      neg_in     = neg_ff;
      asym_in    = asym_ff;
      rd_addr    = addr_ff;
      wr_en_f    = 1'b0;
      wr_en_b    = 1'b0;
      wr_data    = cur + 1'b1;
      div_req    = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               if (cmd.rd) begin
                  rd_addr  = cmd.bin[BIN_IDX_W-1:0];
                  addr_in  = cmd.bin[BIN_IDX_W-1:0];
                  zero_in  = !(READ_CMP_W'(cmd.bin) < READ_CMP_W'(BINS));
                  state_in = S_FETCH;
               end else if (in_range) begin
                  div_req.start = 1'b1;
                  div_req.steps = STEP_W'(BIN_IDX_W);
                  div_req.num   = bin_num;
                  div_req.den   = DIV_NW'(span) << (BIN_IDX_W - 1);
                  fwd_in        = (cmd.angle != '0) && !cmd.angle[ANGLE_W-1];
                  state_in      = S_BIN;
               end
            end
         end
         S_BIN: begin
            if (div_rsp.done) begin
               rd_addr  = div_rsp.quot[BIN_IDX_W-1:0];
               addr_in  = div_rsp.quot[BIN_IDX_W-1:0];
               state_in = S_INC;
            end
         end
         S_INC: begin
            // saturating bump, read data arrived this cycle
            if (cur != COUNT_MAX) begin
               wr_en_f = fwd_ff;
               wr_en_b = !fwd_ff;
               if (fwd_ff) begin
                  valid_f_in[addr_ff] = 1'b1;
               end else begin
                  valid_b_in[addr_ff] = 1'b1;
               end
            end
            state_in = S_IDLE;
         end
         S_FETCH: begin
            f_in     = zero_ff ? '0 : cur_f;
            b_in     = zero_ff ? '0 : cur_b;
            state_in = S_PREP;
         end
         S_PREP: begin
            sum_in   = SUM_W'(f_ff) + SUM_W'(b_ff);
            neg_in   = b_ff > f_ff;
            diff_in  = (b_ff > f_ff) ? (b_ff - f_ff) : (f_ff - b_ff);
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            if (sum_ff == '0) begin
               asym_in  = '0;
               state_in = S_DONE;
            end else begin
               // round half away from zero: add sum/2 before dividing
               div_req.start = 1'b1;
               div_req.steps = STEP_W'(ASYM_STEPS);
               div_req.num   = (DIV_NW'(diff_ff) << FRAC_BITS) + DIV_NW'(sum_ff >> 1);
               div_req.den   = DIV_NW'(sum_ff) << FRAC_BITS;
               state_in      = S_ASYM;
            end
         end
         S_ASYM: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  asym_in = $signed(ASYM_W'(0) - ASYM_W'(mag));
               end else if (mag[QUOT_W-1]) begin
                  asym_in = $signed(ASYM_POS_MAX);
               end else begin
                  asym_in = $signed(ASYM_W'(mag));
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_f_ff <= '0;
         valid_b_ff <= '0;
      end else begin
         state_ff   <= state_in;
         valid_f_ff <= valid_f_in;
         valid_b_ff <= valid_b_in;
      end
      addr_ff <= addr_in;
      fwd_ff  <= fwd_in;
      zero_ff <= zero_in;
      f_ff    <= f_in;
      b_ff    <= b_in;
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
      neg_ff  <= neg_in;
      asym_ff <= asym_in;
   end

   assign stat.idle     = (state_ff == S_IDLE);
   assign stat.done     = (state_ff == S_DONE);
   assign stat.forward  = f_ff;
   assign stat.backward = b_ff;
   assign stat.asym     = asym_ff;

endmodule

>>> sv/forward_backward_asymmetry_histogram.sv
// Event transaction: no lane work if both levels fall outside the mass range,
//   else each in-range lane runs the bin division, then bumps its bin count.
// Read transaction: result registered after the fetch, the prep and the 16-step
//   Q1.15 asymmetry division, skipped for an empty bin; next item taken the
//   cycle after the result is loaded into the output register.
// Reset (synchronous, active high) clears all bin counts at once through
//   per-entry valid bits; min_mass = 0, max_mass = 65535. No clearing pass.
`timescale 1ns / 1ps
`include "forward_backward_asymmetry_histogram_assert.svh"
module forward_backward_asymmetry_histogram
   import fbah_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input transactions
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // result transactions
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [MASS_W-1:0]      csr_data
);

   // Two lanes, generator level and reconstructed level, each with its own
   // forward/backward RAM pair and its own divider. Both take every
   // transaction together; the merge stage below joins their read results.

   logic [MASS_W-1:0]   min_mass_ff, min_mass_in;
   logic [MASS_W-1:0]   max_mass_ff, max_mass_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [IN_BIN_W-1:0] bin_ff, bin_in;

   logic          req_accept;
   logic          lane_take;
   lane_cmd_type  gen_cmd, reco_cmd;
   lane_stat_type gen_st, reco_st;

   // a new transaction waits until both lanes are back to idle
   assign req_stall  = !(gen_st.idle && reco_st.idle);
   assign req_accept = req_valid && !req_stall;

   assign gen_cmd.start  = req_accept;
   assign gen_cmd.rd     = (req_data.cmd == CMD_READ);
   assign gen_cmd.angle  = req_data.gen_angle;
   assign gen_cmd.mass   = req_data.gen_mass;
   assign gen_cmd.bin    = req_data.read_bin;

   assign reco_cmd.start = req_accept;
   assign reco_cmd.rd    = (req_data.cmd == CMD_READ);
   assign reco_cmd.angle = req_data.reco_angle;
   assign reco_cmd.mass  = req_data.reco_mass;
   assign reco_cmd.bin   = req_data.read_bin;

   fbah_lane u_gen_lane (
      .clock    (clock),
      .reset    (reset),
      .min_mass (min_mass_ff),
      .max_mass (max_mass_ff),
      .cmd      (gen_cmd),
      .take     (lane_take),
      .stat     (gen_st)
   );

   fbah_lane u_reco_lane (
      .clock    (clock),
      .reset    (reset),
      .min_mass (min_mass_ff),
      .max_mass (max_mass_ff),
      .cmd      (reco_cmd),
      .take     (lane_take),
      .stat     (reco_st)
   );

   // Merge: load the output register once both lanes finished and the
   // register is free or draining this cycle.
   assign lane_take = gen_st.done && reco_st.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      min_mass_in  = min_mass_ff;
      max_mass_in  = max_mass_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      bin_in       = bin_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_MASS: min_mass_in = csr_data;
            CSR_MAX_MASS: max_mass_in = csr_data;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end

      if (req_accept && (req_data.cmd == CMD_READ)) begin
         bin_in = req_data.read_bin;
      end

      if (lane_take) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_bin       = bin_ff;
         rsp_data_in.gen_forward   = OUT_COUNT_W'(gen_st.forward);
         rsp_data_in.gen_backward  = OUT_COUNT_W'(gen_st.backward);
         rsp_data_in.reco_forward  = OUT_COUNT_W'(reco_st.forward);
         rsp_data_in.reco_backward = OUT_COUNT_W'(reco_st.backward);
         rsp_data_in.gen_asym      = gen_st.asym;
         rsp_data_in.reco_asym     = reco_st.asym;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_mass_ff  <= '0;
         max_mass_ff  <= MAX_MASS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_mass_ff  <= min_mass_in;
         max_mass_ff  <= max_mass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      bin_ff      <= bin_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a read transaction keeps both lanes busy on the following cycle
   `FBAH_ASSERT_NEXT(a_read_blocks_input, clock, reset, req_accept && (req_data.cmd == CMD_READ), req_stall)
   // a lane that finished first holds its result for its partner
   `FBAH_ASSERT_NEXT(a_gen_waits, clock, reset, gen_st.done && !reco_st.done, gen_st.done)
   `FBAH_ASSERT_NEXT(a_reco_waits, clock, reset, reco_st.done && !gen_st.done, reco_st.done)
   // the output register is only filled from two finished lanes
   `FBAH_ASSERT_NOW(a_rsp_from_lanes, clock, reset, $rose(rsp_valid_ff), $past(gen_st.done && reco_st.done))

endmodule
